>>> rtl/text_command_to_can_frame_unit_assert.svh
// Assertion macros shared by the text command to CAN frame unit.
// Each macro expects clk and arst_n in scope.
`ifndef TEXT_COMMAND_TO_CAN_FRAME_UNIT_ASSERT_SVH
`define TEXT_COMMAND_TO_CAN_FRAME_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TCCF_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TCCF_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tccf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccf_pkg
// Types, character codes and hex conversion for the text command parser.
// ----------------------------------------------------------------------------
package tccf_pkg;

	localparam int IDX_W     = 4;
	localparam int NUM_DATA  = 8;
	localparam int ID_SLOTS  = 3;
	localparam int DAT_SLOTS = 2;

	localparam logic [IDX_W-1:0] INDEX_MAX = 4'd10;
	localparam logic [IDX_W-1:0] INDEX_ID  = 4'd1;

	localparam logic [7:0] CH_START = 8'h53;  // 'S'
	localparam logic [7:0] CH_ECHO  = 8'h55;  // 'U'
	localparam logic [7:0] CH_END   = 8'h23;  // '#'
	localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'b001,
		MODE_FRAME = 3'b010,
		MODE_ECHO  = 3'b100
	} mode_t;

	typedef struct packed {
		logic clear;
		logic wr;
		logic emit_frame;
		logic emit_echo;
	} ctl_t;

	typedef struct packed {
		mode_t            mode;
		logic [IDX_W-1:0] field_index;
		logic             after_space;
	} st_t;

	function automatic logic [3:0] hex_digit(input logic [7:0] c);
		logic [3:0] d;
		d = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) d = 4'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66) d = 4'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h46) d = 4'(c - 8'h37);
		return d;
	endfunction

endpackage

>>> rtl/tccf_field.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccf_field
// One field of the character store with its hex value.
// ----------------------------------------------------------------------------
module tccf_field #(
	parameter int SLOTS = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clear,
	input  logic                 we,
	input  logic [7:0]           wr_char,
	output logic [4*SLOTS-1:0]   value
);

	localparam int SEL_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [7:0]       slot_q [SLOTS];
	logic [SEL_W-1:0] sel;

	// first empty slot, else the last slot (overwritten on overflow)
	always_comb begin
		logic found;
		found = 1'b0;
		sel   = SEL_W'(SLOTS - 1);
		for (int i = 0; i < SLOTS - 1; i++) begin
			if (!found && slot_q[i] == 8'd0) begin
				sel   = SEL_W'(i);
				found = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) slot_q[i] <= 8'd0;
		end else if (clear) begin
			for (int i = 0; i < SLOTS; i++) slot_q[i] <= 8'd0;
		end else if (we) begin
			slot_q[sel] <= wr_char;
		end
	end

	// convert until the first empty slot
	always_comb begin
		logic stop;
		stop  = 1'b0;
		value = '0;
		for (int k = 0; k < SLOTS; k++) begin
			if (!stop) begin
				if (slot_q[k] == 8'd0) begin
					stop = 1'b1;
				end else begin
					value = {value[4*SLOTS-5:0], tccf_pkg::hex_digit(slot_q[k])};
				end
			end
		end
	end

endmodule

>>> rtl/tccf_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccf_parser
// Command state: mode, field index and space tracking.
// ----------------------------------------------------------------------------
module tccf_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     rx_byte,
	output tccf_pkg::ctl_t ctl,
	output tccf_pkg::st_t  st
);

	tccf_pkg::mode_t                 mode_q, mode_d;
	logic [tccf_pkg::IDX_W-1:0]      idx_q, idx_d;
	logic                            as_q, as_d;

	always_comb begin
		ctl    = '0;
		mode_d = mode_q;
		idx_d  = idx_q;
		as_d   = as_q;
		unique case (mode_q)
			tccf_pkg::MODE_FRAME: begin
				if (rx_byte == tccf_pkg::CH_END) begin
					ctl.emit_frame = 1'b1;
					as_d           = 1'b0;
					mode_d         = tccf_pkg::MODE_IDLE;
				end else if (rx_byte == tccf_pkg::CH_SPACE) begin
					// only the first space of a run advances
					if (!as_q && idx_q < tccf_pkg::INDEX_MAX) idx_d = idx_q + 4'd1;
					as_d = 1'b1;
				end else if (idx_q < tccf_pkg::INDEX_MAX && idx_q != '0) begin
					ctl.wr = 1'b1;
					as_d   = 1'b0;
				end
			end
			tccf_pkg::MODE_ECHO: begin
				if (rx_byte == tccf_pkg::CH_END) mode_d = tccf_pkg::MODE_IDLE;
				else ctl.emit_echo = 1'b1;
			end
			default: begin
				if (rx_byte == tccf_pkg::CH_START) begin
					ctl.clear = 1'b1;
					as_d      = 1'b1;
					idx_d     = tccf_pkg::INDEX_ID;
					mode_d    = tccf_pkg::MODE_FRAME;
				end else if (rx_byte == tccf_pkg::CH_ECHO) begin
					mode_d = tccf_pkg::MODE_ECHO;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tccf_pkg::MODE_IDLE;
			idx_q  <= '0;
			as_q   <= 1'b0;
		end else if (step) begin
			mode_q <= mode_d;
			idx_q  <= idx_d;
			as_q   <= as_d;
		end
	end

	assign st.mode        = mode_q;
	assign st.field_index = idx_q;
	assign st.after_space = as_q;

endmodule

>>> rtl/text_command_to_can_frame_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_command_to_can_frame_unit
// Parses ASCII command bytes into CAN frames (id + 8 data bytes) or echoes.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   rx_byte
//  out      out_valid / out_ready kind, echo_byte, frame_id, byte0..byte7
//
// One byte per cycle unless a result is held at the output. A byte is
// registered on transfer, decoded against the parser state and field store
// the next cycle, and any result lands in the output register. A byte that
// yields a result waits in the input register while the output register is
// full and not taken. Reset clears mode, index and the field store.
`include "text_command_to_can_frame_unit_assert.svh"

module text_command_to_can_frame_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  echo_byte,
	output logic [11:0] frame_id,
	output logic [7:0]  byte0,
	output logic [7:0]  byte1,
	output logic [7:0]  byte2,
	output logic [7:0]  byte3,
	output logic [7:0]  byte4,
	output logic [7:0]  byte5,
	output logic [7:0]  byte6,
	output logic [7:0]  byte7
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fire_s1;
	logic       needs_out;

	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  echo_q;
	logic [11:0] id_q;
	logic [7:0]  data_q [tccf_pkg::NUM_DATA];

	tccf_pkg::ctl_t ctl;
	tccf_pkg::st_t  st;

	logic [11:0] id_val;
	logic [7:0]  data_val [tccf_pkg::NUM_DATA];

	assign needs_out = ctl.emit_frame | ctl.emit_echo;
	assign fire_s1   = valid_s1 && (!needs_out || !out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= rx_byte;
	end

	tccf_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (fire_s1),
		.rx_byte (byte_s1),
		.ctl     (ctl),
		.st      (st)
	);

	tccf_field #(.SLOTS(tccf_pkg::ID_SLOTS)) u_id (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (fire_s1 && ctl.clear),
		.we      (fire_s1 && ctl.wr && st.field_index == tccf_pkg::INDEX_ID),
		.wr_char (byte_s1),
		.value   (id_val)
	);

	for (genvar f = 0; f < tccf_pkg::NUM_DATA; f++) begin : g_data
		tccf_field #(.SLOTS(tccf_pkg::DAT_SLOTS)) u_dat (
			.clk     (clk),
			.arst_n  (arst_n),
			.clear   (fire_s1 && ctl.clear),
			.we      (fire_s1 && ctl.wr && st.field_index == tccf_pkg::IDX_W'(f + 2)),
			.wr_char (byte_s1),
			.value   (data_val[f])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && needs_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && needs_out) begin
			kind_q <= ctl.emit_echo;
			echo_q <= ctl.emit_echo ? byte_s1 : 8'd0;
			id_q   <= ctl.emit_echo ? 12'd0 : id_val;
			for (int j = 0; j < tccf_pkg::NUM_DATA; j++)
				data_q[j] <= ctl.emit_echo ? 8'd0 : data_val[j];
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign echo_byte = echo_q;
	assign frame_id  = id_q;
	assign byte0     = data_q[0];
	assign byte1     = data_q[1];
	assign byte2     = data_q[2];
	assign byte3     = data_q[3];
	assign byte4     = data_q[4];
	assign byte5     = data_q[5];
	assign byte6     = data_q[6];
	assign byte7     = data_q[7];

	`TCCF_ASSERT_NOW(a_stall_cause, !in_ready, valid_s1 && needs_out && out_valid_q && !out_ready, "input stalled without a blocked result")
	`TCCF_ASSERT_NOW(a_index_sat, 1'b1, st.field_index <= tccf_pkg::INDEX_MAX, "field index past saturation")
	`TCCF_ASSERT_NEXT(a_start, fire_s1 && ctl.clear, st.field_index == tccf_pkg::INDEX_ID && st.after_space, "start did not reset the field index")
	`TCCF_ASSERT_NOW(a_echo_clean, out_valid_q && kind_q, id_q == 12'd0 && data_q[0] == 8'd0, "echo result carries frame data")

endmodule

>>> verif/text_command_to_can_frame_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_command_to_can_frame_unit_checker
// Watches both channels of the text command parser. It keeps its own copy
// of the parser state and field store, works out the frame or echo that
// each input transfer yields, and compares every output transfer with the
// oldest one still due. Mismatches are counted and reported with the time.
// ----------------------------------------------------------------------------
module text_command_to_can_frame_unit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        kind,
	input  logic [7:0]  echo_byte,
	input  logic [11:0] frame_id,
	input  logic [7:0]  byte0,
	input  logic [7:0]  byte1,
	input  logic [7:0]  byte2,
	input  logic [7:0]  byte3,
	input  logic [7:0]  byte4,
	input  logic [7:0]  byte5,
	input  logic [7:0]  byte6,
	input  logic [7:0]  byte7,
	output int          mismatches,
	output int          results_pending,
	output int          frames_seen,
	output int          echoes_seen
);

	localparam int STORE_DEPTH = 9 * tccf_pkg::ID_SLOTS;

	typedef struct packed {
		logic                                kind;
		logic [7:0]                          echo;
		logic [11:0]                         id;
		logic [tccf_pkg::NUM_DATA-1:0][7:0]  data;
	} can_result_t;

	can_result_t                results_due[$];
	tccf_pkg::mode_t            parse_mode;
	logic [tccf_pkg::IDX_W-1:0] field_pos;
	logic                       space_seen;
	logic [7:0]                 char_slots [0:STORE_DEPTH-1];
	int                         field_errors;

	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return 4'(c - "0");
		if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
		if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
		return 4'd0;
	endfunction

	// Stop at the first empty slot of the field.
	function automatic logic [11:0] field_hex(input int f, input int len);
		logic [11:0] v;
		v = '0;
		for (int k = 0; k < len; k++) begin
			if (char_slots[f * tccf_pkg::ID_SLOTS + k] == 8'h00) break;
			v = {v[7:0], nibble_of(char_slots[f * tccf_pkg::ID_SLOTS + k])};
		end
		return v;
	endfunction

	function automatic void absorb_byte(input logic [7:0] c);
		can_result_t r;
		logic [11:0] v;
		int          base;
		int          lim;
		int          i;
		r = '0;
		case (parse_mode)
			tccf_pkg::MODE_FRAME: begin
				if (c == tccf_pkg::CH_END) begin
					space_seen = 1'b0;
					parse_mode = tccf_pkg::MODE_IDLE;
					r.id = field_hex(0, tccf_pkg::ID_SLOTS);
					for (int j = 0; j < tccf_pkg::NUM_DATA; j++) begin
						v = field_hex(j + 1, tccf_pkg::DAT_SLOTS);
						r.data[j] = v[7:0];
					end
					results_due.push_back(r);
				end else if (c == tccf_pkg::CH_SPACE) begin
					// only the first space of a run advances the field
					if (!space_seen && field_pos < tccf_pkg::INDEX_MAX)
						field_pos = field_pos + 1'b1;
					space_seen = 1'b1;
				end else if (field_pos < tccf_pkg::INDEX_MAX &&
						field_pos >= tccf_pkg::INDEX_ID) begin
					base = (int'(field_pos) - 1) * tccf_pkg::ID_SLOTS;
					lim = (field_pos == tccf_pkg::INDEX_ID) ? tccf_pkg::ID_SLOTS - 1
						: tccf_pkg::DAT_SLOTS - 1;
					i = 0;
					space_seen = 1'b0;
					// overflow lands on the last slot of the field
					while (i < lim && char_slots[base + i] != 8'h00)
						i++;
					char_slots[base + i] = c;
				end
			end
			tccf_pkg::MODE_ECHO: begin
				if (c == tccf_pkg::CH_END) begin
					parse_mode = tccf_pkg::MODE_IDLE;
				end else begin
					r.kind = 1'b1;
					r.echo = c;
					results_due.push_back(r);
				end
			end
			default: begin
				if (c == tccf_pkg::CH_START) begin
					space_seen = 1'b1;
					field_pos = tccf_pkg::INDEX_ID;
					for (int k = 0; k < STORE_DEPTH; k++)
						char_slots[k] = 8'h00;
					parse_mode = tccf_pkg::MODE_FRAME;
				end else if (c == tccf_pkg::CH_ECHO) begin
					parse_mode = tccf_pkg::MODE_ECHO;
				end
			end
		endcase
	endfunction

	function automatic void check_field(input string label, input logic [11:0] want,
			input logic [11:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, label, want, got);
			field_errors++;
		end
	endfunction

	function automatic void compare_result(input can_result_t got);
		can_result_t want;
		if (results_due.size() == 0) begin
			$display("%0t ns: unexpected result, actual kind %b echo %h id %h data %h",
				$time, got.kind, got.echo, got.id, got.data);
			field_errors++;
			return;
		end
		want = results_due.pop_front();
		check_field("kind", 12'(want.kind), 12'(got.kind));
		check_field("echo_byte", 12'(want.echo), 12'(got.echo));
		check_field("frame_id", want.id, got.id);
		for (int j = 0; j < tccf_pkg::NUM_DATA; j++)
			check_field($sformatf("byte%0d", j), 12'(want.data[j]), 12'(got.data[j]));
		if (want.kind)
			echoes_seen++;
		else
			frames_seen++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		can_result_t got;
		if (!arst_n) begin
			parse_mode = tccf_pkg::MODE_IDLE;
			field_pos = '0;
			space_seen = 1'b0;
			for (int k = 0; k < STORE_DEPTH; k++)
				char_slots[k] = 8'h00;
			results_due.delete();
			field_errors = 0;
			frames_seen = 0;
			echoes_seen = 0;
			mismatches <= 0;
			results_pending <= 0;
		end else begin
			// a result leaving now always predates a byte arriving now
			if (out_valid && out_ready) begin
				got.kind = kind;
				got.echo = echo_byte;
				got.id = frame_id;
				got.data = {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0};
				compare_result(got);
			end
			if (in_valid && in_ready)
				absorb_byte(rx_byte);
			mismatches <= field_errors;
			results_pending <= results_due.size();
		end
	end

endmodule

>>> verif/text_command_to_can_frame_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_command_to_can_frame_unit_tb
// Feeds the text command parser with directed commands, then random frame,
// echo and noise sequences under three mixes of sender and receiver idling
// plus one long output hold. The checker predicts and compares results.
// ----------------------------------------------------------------------------
module text_command_to_can_frame_unit_tb;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BYTES = 1600;
	localparam int HOLD_CYCLES  = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [7:0]  echo_byte;
	logic [11:0] frame_id;
	logic [7:0]  byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7;
	int          mismatches;
	int          results_pending;
	int          frames_seen;
	int          echoes_seen;

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int hold_req = 0;
	int hold_served = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int bytes_sent = 0;

	text_command_to_can_frame_unit u_top (.*);

	text_command_to_can_frame_unit_checker u_checker (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("text_command_to_can_frame_unit_tb: FAIL");
			$finish;
		end
	end

	// Receiver: random back-pressure, plus a long hold whenever one is requested.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_req) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_served <= hold_req;
		end else begin
			out_ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Offer one byte and hold it until the transfer.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int k = 0; k < s.len(); k++)
			send_byte(s[k]);
	endtask

	function automatic logic [7:0] pick_field_char();
		string hex_set;
		int    r;
		logic [7:0] b;
		hex_set = "0123456789abcdefABCDEF";
		r = $urandom_range(99);
		if (r < 80)
			return hex_set[$urandom_range(hex_set.len() - 1)];
		b = 8'($urandom_range(255));
		// mostly keep stray bytes from ending the frame early
		if (r < 95 && b == tccf_pkg::CH_END)
			b = 8'h00;
		return b;
	endfunction

	task automatic send_frame();
		int nf;
		int nc;
		send_byte(tccf_pkg::CH_START);
		nf = ($urandom_range(1) == 0) ? 9 : $urandom_range(11);
		if ($urandom_range(9) == 0)
			send_byte(tccf_pkg::CH_SPACE);
		for (int f = 0; f < nf; f++) begin
			if (f > 0)
				repeat (($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1)
					send_byte(tccf_pkg::CH_SPACE);
			nc = (f == 0) ? $urandom_range(4) : $urandom_range(3);
			repeat (nc)
				send_byte(pick_field_char());
		end
		send_byte(tccf_pkg::CH_END);
	endtask

	task automatic send_echo(input int n);
		logic [7:0] b;
		send_byte(tccf_pkg::CH_ECHO);
		repeat (n) begin
			b = 8'($urandom_range(255));
			if (b == tccf_pkg::CH_END)
				b = tccf_pkg::CH_SPACE;
			send_byte(b);
		end
		send_byte(tccf_pkg::CH_END);
	endtask

	// Idle noise; these bytes do not count toward the random budget.
	task automatic send_noise();
		int before_noise;
		before_noise = bytes_sent;
		repeat ($urandom_range(1, 4))
			send_byte(8'($urandom_range(255)));
		send_byte(tccf_pkg::CH_END);
		bytes_sent = before_noise;
	endtask

	initial begin
		int target;
		int pick;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 24;
		snk_idle_pct <= 71;

		// echo of the extremes, then a start byte echoed and the exit
		send_byte(tccf_pkg::CH_ECHO);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(tccf_pkg::CH_START);
		send_byte(tccf_pkg::CH_END);
		// ignored in idle
		send_text("x#");
		// identifier overflow, space run, mixed case, zero byte, non-hex
		send_text("S1234  Ab ");
		send_byte(8'h00);
		send_text(" z#");
		// empty frame
		send_text("S#");

		bytes_sent = 0;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 24;
					snk_idle_pct <= 71;
				end
				1: begin
					src_idle_pct = 71;
					snk_idle_pct <= 24;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct <= 0;
					// hold the output off while echoes keep coming
					hold_req <= hold_req + 1;
					send_echo(40);
				end
			endcase
			target = RANDOM_BYTES * (phase + 1) / 3;
			while (bytes_sent < target) begin
				pick = $urandom_range(99);
				if (pick < 55)
					send_frame();
				else if (pick < 85)
					send_echo($urandom_range(12));
				else
					send_noise();
			end
		end
		in_valid <= 1'b0;
		// let the checker count the last transfer before polling
		@(posedge clk);

		while (results_pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Checked %0d frames and %0d echoed bytes from random command streams",
			frames_seen, echoes_seen);
		$display("under three idling mixes and a %0d-cycle output hold.", HOLD_CYCLES);
		if (mismatches == 0)
			$display("text_command_to_can_frame_unit_tb: PASS");
		else
			$display("text_command_to_can_frame_unit_tb: FAIL");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/tccf_pkg.sv
rtl/tccf_field.sv
rtl/tccf_parser.sv
rtl/text_command_to_can_frame_unit.sv
verif/text_command_to_can_frame_unit_checker.sv
verif/text_command_to_can_frame_unit_tb.sv
